### hw/rtl/s4rc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s4rc_pkg
// Types, codes and helpers shared by the SOCKS4 request rule check block.
// ----------------------------------------------------------------------------
package s4rc_pkg;

	// Default rule table depth
	localparam int RULE_SLOTS_DEF = 16;

	// Item kinds
	localparam logic REQ_RULE_WRITE = 1'b0;
	localparam logic REQ_CHECK      = 1'b1;

	// Protocol constants
	localparam logic [7:0] SOCKS_VERSION  = 8'd4;
	localparam logic [7:0] CMD_CONNECT    = 8'd1;
	localparam logic [6:0] REPLY_GRANTED  = 7'd90;
	localparam logic [6:0] REPLY_REJECTED = 7'd91;

	// Input word: rule write or request check
	typedef struct packed {
		logic        req_type;
		logic [3:0]  rule_slot;
		logic        rule_valid;
		logic        rule_is_bind;
		logic [31:0] rule_address;
		logic [3:0]  rule_wildcards;
		logic [7:0]  version;
		logic [7:0]  command;
		logic [15:0] dest_port;
		logic [31:0] dest_address;
	} in_word_t;

	// Result word
	typedef struct packed {
		logic [6:0]  reply_code;
		logic        is_bind;
		logic        matched;
		logic [3:0]  matched_slot;
		logic [15:0] echo_port;
	} out_word_t;

	// Stored rule body (valid bit lives in flops)
	typedef struct packed {
		logic        is_bind;
		logic [31:0] address;
		logic [3:0]  wildcards;
	} rule_t;

	// Byte mask of octets that must compare equal
	function automatic logic [31:0] compare_mask(input logic [3:0] wildcards);
		logic [31:0] mask;
		mask = '0;
		for (int i = 0; i < 4; i++) begin
			if (!wildcards[i]) begin
				mask[8*i +: 8] = 8'hFF;
			end
		end
		return mask;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/socks4_request_rule_check.sv
`default_nettype none
// A rule-write word gives no result and leaves the sequencer idle, so the block stays ready.
// A check word shows its result once slot s is the first hit or, when nothing hits, once the
// last slot has been compared; the next word is taken only after the result is accepted.
// The scan does one slot read per cycle into one shared compare unit, through the read stage
// (rule_s1) and then the result registers (hit_q, hit_slot_q).
// Reset clears all rule valid bits and the sequencer; rule bodies are undefined until written.
// ----------------------------------------------------------------------------
// socks4_request_rule_check
// Rule table with a sequential scan that grants or rejects SOCKS4 requests.
// ----------------------------------------------------------------------------
module socks4_request_rule_check #(
	parameter int RULE_SLOTS = s4rc_pkg::RULE_SLOTS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   item_valid,
	output logic                  item_ready,
	input  wire s4rc_pkg::in_word_t  item,
	output logic                  result_valid,
	input  wire                   result_ready,
	output s4rc_pkg::out_word_t   result
);
	import s4rc_pkg::*;

	localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
	localparam int CNT_W = $clog2(RULE_SLOTS + 1);

	// Sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]            state_q;
	logic [RULE_SLOTS-1:0] valid_q;
	logic [CNT_W-1:0]      iss_q;
	logic                  rd_vld_s1;
	logic                  rule_vld_s1;
	logic [IDX_W-1:0]      slot_s1;
	rule_t                 rule_s1;
	logic                  hit_q;
	logic [IDX_W-1:0]      hit_slot_q;

	// Request fields held over the scan
	logic                  bind_q;
	logic [7:0]            version_q;
	logic [15:0]           port_q;
	logic [31:0]           addr_q;

	rule_t                 mem [RULE_SLOTS];

	logic                  accept;
	logic                  wr_en;
	logic [8:0]            wr_slot;
	logic                  issuing;
	logic [IDX_W-1:0]      iss_idx;
	logic                  cmp_hit;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = (state_q == ST_DONE);
	assign accept       = item_valid && item_ready;
	assign wr_slot      = 9'(item.rule_slot);
	assign wr_en        = accept && (item.req_type == REQ_RULE_WRITE)
	                      && (wr_slot < 9'(RULE_SLOTS));
	assign issuing      = (state_q == ST_SCAN) && (iss_q < CNT_W'(RULE_SLOTS));
	assign iss_idx      = iss_q[IDX_W-1:0];

	// Rule memory: written in idle, read one slot per cycle during the scan
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_slot[IDX_W-1:0]] <= rule_t'{
				is_bind:   item.rule_is_bind,
				address:   item.rule_address,
				wildcards: item.rule_wildcards
			};
		end
		if (issuing) begin
			rule_s1 <= mem[iss_idx];
		end
	end

	// Request capture and read pipeline payload
	always_ff @(posedge clk) begin
		if (accept && (item.req_type == REQ_CHECK)) begin
			bind_q    <= (item.command != CMD_CONNECT);
			version_q <= item.version;
			port_q    <= item.dest_port;
			addr_q    <= item.dest_address;
		end
		if (issuing) begin
			slot_s1     <= iss_idx;
			rule_vld_s1 <= valid_q[iss_idx];
		end
	end

	// Shared compare unit
	s4rc_match u_match (
		.rule        (rule_s1),
		.rule_valid  (rule_vld_s1),
		.req_bind    (bind_q),
		.req_address (addr_q),
		.hit         (cmp_hit)
	);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_slot[IDX_W-1:0]] <= item.rule_valid;
		end
	end

	// Scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			iss_q      <= '0;
			rd_vld_s1  <= 1'b0;
			hit_q      <= 1'b0;
			hit_slot_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (item.req_type == REQ_CHECK)) begin
						state_q    <= ST_SCAN;
						iss_q      <= '0;
						rd_vld_s1  <= 1'b0;
						hit_q      <= 1'b0;
						hit_slot_q <= '0;
					end
				end
				ST_SCAN: begin
					if (issuing) begin
						iss_q <= iss_q + CNT_W'(1);
					end
					// First hit ends the scan; otherwise stop after the last slot
					if (rd_vld_s1 && cmp_hit) begin
						hit_q      <= 1'b1;
						hit_slot_q <= slot_s1;
						rd_vld_s1  <= 1'b0;
						state_q    <= ST_DONE;
					end else if (rd_vld_s1 && (slot_s1 == IDX_W'(RULE_SLOTS - 1))) begin
						rd_vld_s1 <= 1'b0;
						state_q   <= ST_DONE;
					end else begin
						rd_vld_s1 <= issuing;
					end
				end
				ST_DONE: begin
					if (result_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result word
	always_comb begin
		result.reply_code   = (hit_q && (version_q == SOCKS_VERSION)) ? REPLY_GRANTED
		                                                            : REPLY_REJECTED;
		result.is_bind      = bind_q;
		result.matched      = hit_q;
		result.matched_slot = 4'(hit_slot_q);
		result.echo_port    = port_q;
	end

	// Checks
	a_busy_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !item_ready)
		else $error("input taken while a result is pending");

	a_grant_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.reply_code == REPLY_GRANTED)) |-> result.matched)
		else $error("grant without a matching rule");

	a_check_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (item.req_type == REQ_CHECK)) |=> (state_q == ST_SCAN) && !rd_vld_s1)
		else $error("check word did not start a scan");

	a_scan_leaves_no_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SCAN) |-> !rd_vld_s1)
		else $error("read pipeline busy outside scan");

endmodule
`default_nettype wire

### hw/rtl/s4rc_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s4rc_match
// Shared compare unit: tests one stored rule against the request under scan.
// ----------------------------------------------------------------------------
module s4rc_match (
	input  wire s4rc_pkg::rule_t rule,
	input  wire                  rule_valid,
	input  wire                  req_bind,
	input  wire [31:0]           req_address,
	output logic                 hit
);
	import s4rc_pkg::*;

	logic [31:0] mask;

	// Type must agree and every non-wildcard octet must be equal
	always_comb begin
		mask = compare_mask(rule.wildcards);
		hit  = rule_valid && (rule.is_bind == req_bind)
		       && (((rule.address ^ req_address) & mask) == 32'd0);
	end

endmodule
`default_nettype wire
